[rtl/core/bpo_pkg.sv]
`default_nettype none
package bpo_pkg;

    localparam int unsigned CoordW   = 16;
    localparam int unsigned EdgeW    = CoordW + 1;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned AreaW    = 2 * CoordW;
    localparam int unsigned AreaSumW = AreaW + 1;
    localparam int unsigned OvlW     = 2 * EdgeW;
    // 2 * ow * oh * 65536: one bit for the factor two, CoordW for the Q0.16 scale
    localparam int unsigned LhsW     = OvlW + 1 + CoordW;
    localparam int unsigned RhsW     = CoordW + AreaSumW;
    localparam int unsigned RatioW   = 2 * CoordW;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_OVERLAP      = 3'd0,
        REG_MIN_WIDTH_RATIO  = 3'd1,
        REG_MAX_WIDTH_RATIO  = 3'd2,
        REG_MIN_HEIGHT_RATIO = 3'd3,
        REG_MAX_HEIGHT_RATIO = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic [CoordW-1:0] first_x;
        logic [CoordW-1:0] first_y;
        logic [CoordW-1:0] first_width;
        logic [CoordW-1:0] first_height;
        logic [CoordW-1:0] second_x;
        logic [CoordW-1:0] second_y;
        logic [CoordW-1:0] second_width;
        logic [CoordW-1:0] second_height;
    } box_pair_t;

    typedef struct packed {
        logic accepted;
        logic disjoint;
        logic overlap_ok;
        logic width_ratio_ok;
        logic height_ratio_ok;
    } match_result_t;

    typedef struct packed {
        logic [CoordW-1:0] min_overlap;
        logic [CoordW-1:0] min_width_ratio;
        logic [CoordW-1:0] max_width_ratio;
        logic [CoordW-1:0] min_height_ratio;
        logic [CoordW-1:0] max_height_ratio;
    } cfg_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic              disjoint;
        logic [EdgeW-1:0]  ow;
        logic [EdgeW-1:0]  oh;
        logic [CoordW-1:0] w1;
        logic [CoordW-1:0] h1;
        logic [CoordW-1:0] w2;
        logic [CoordW-1:0] h2;
    } geom_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic              disjoint;
        logic [OvlW-1:0]   ovl_prod;
        logic [AreaW-1:0]  area1;
        logic [AreaW-1:0]  area2;
        logic [CoordW-1:0] w1;
        logic [CoordW-1:0] h1;
        logic              w2_zero;
        logic              h2_zero;
        logic [RatioW-1:0] w_lo;
        logic [RatioW-1:0] w_hi;
        logic [RatioW-1:0] h_lo;
        logic [RatioW-1:0] h_hi;
    } prod_t;

endpackage
`default_nettype wire

[rtl/core/bpo_geom.sv]
`default_nettype none
module bpo_geom
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire bpo_pkg::box_pair_t    boxes,
    output logic                       out_valid,
    output bpo_pkg::geom_t             geom
);

    logic                        valid_reg;
    bpo_pkg::geom_t              geom_reg;
    bpo_pkg::geom_t              geom_next;
    logic [bpo_pkg::EdgeW-1:0]   x1, y1, x2, y2, r1, b1, r2, b2;
    logic [bpo_pkg::EdgeW-1:0]   right_min, bottom_min, left_max, top_max;

    always_comb
    begin
        x1 = {1'b0, boxes.first_x};
        y1 = {1'b0, boxes.first_y};
        x2 = {1'b0, boxes.second_x};
        y2 = {1'b0, boxes.second_y};
        r1 = x1 + {1'b0, boxes.first_width};
        b1 = y1 + {1'b0, boxes.first_height};
        r2 = x2 + {1'b0, boxes.second_width};
        b2 = y2 + {1'b0, boxes.second_height};

        right_min  = (r1 < r2) ? r1 : r2;
        bottom_min = (b1 < b2) ? b1 : b2;
        left_max   = (x1 > x2) ? x1 : x2;
        top_max    = (y1 > y2) ? y1 : y2;

        geom_next.disjoint = (x1 > r2) || (y1 > b2) || (r1 < x2) || (b1 < y2);
        // extents wrap when disjoint; masked further down
        geom_next.ow = right_min - left_max;
        geom_next.oh = bottom_min - top_max;
        geom_next.w1 = boxes.first_width;
        geom_next.h1 = boxes.first_height;
        geom_next.w2 = boxes.second_width;
        geom_next.h2 = boxes.second_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        geom_reg <= geom_next;
    end

    assign out_valid = valid_reg;
    assign geom      = geom_reg;

endmodule
`default_nettype wire

[rtl/core/bpo_mult.sv]
`default_nettype none
module bpo_mult
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire bpo_pkg::geom_t    geom,
    input  wire bpo_pkg::cfg_t     cfg,
    output logic                   out_valid,
    output bpo_pkg::prod_t         prod
);

    logic            valid_reg;
    bpo_pkg::prod_t  prod_reg;
    bpo_pkg::prod_t  prod_next;

    always_comb
    begin
        prod_next.disjoint = geom.disjoint;
        prod_next.ovl_prod = bpo_pkg::OvlW'(geom.ow) * bpo_pkg::OvlW'(geom.oh);
        prod_next.area1    = bpo_pkg::AreaW'(geom.w1) * bpo_pkg::AreaW'(geom.h1);
        prod_next.area2    = bpo_pkg::AreaW'(geom.w2) * bpo_pkg::AreaW'(geom.h2);
        prod_next.w1       = geom.w1;
        prod_next.h1       = geom.h1;
        prod_next.w2_zero  = (geom.w2 == '0);
        prod_next.h2_zero  = (geom.h2 == '0);
        prod_next.w_lo     = bpo_pkg::RatioW'(cfg.min_width_ratio) * bpo_pkg::RatioW'(geom.w2);
        prod_next.w_hi     = bpo_pkg::RatioW'(cfg.max_width_ratio) * bpo_pkg::RatioW'(geom.w2);
        prod_next.h_lo     = bpo_pkg::RatioW'(cfg.min_height_ratio) * bpo_pkg::RatioW'(geom.h2);
        prod_next.h_hi     = bpo_pkg::RatioW'(cfg.max_height_ratio) * bpo_pkg::RatioW'(geom.h2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule
`default_nettype wire

[rtl/core/bpo_decide.sv]
`default_nettype none
module bpo_decide
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire bpo_pkg::prod_t          prod,
    input  wire logic [bpo_pkg::CoordW-1:0] min_overlap,
    output logic                         out_valid,
    output bpo_pkg::match_result_t       result
);

    // stage 3: area sum, ratio compares
    logic                          s3_valid_reg;
    logic                          s3_disjoint_reg;
    logic [bpo_pkg::OvlW-1:0]      s3_ovl_reg;
    logic [bpo_pkg::AreaSumW-1:0]  s3_area_sum_reg;
    logic                          s3_wr_ok_reg;
    logic                          s3_hr_ok_reg;
    logic [bpo_pkg::AreaSumW-1:0]  s3_area_sum_next;
    logic                          s3_wr_ok_next;
    logic                          s3_hr_ok_next;
    logic [bpo_pkg::RatioW-1:0]    w1_scaled;
    logic [bpo_pkg::RatioW-1:0]    h1_scaled;

    // stage 4: threshold product
    logic                          s4_valid_reg;
    logic                          s4_disjoint_reg;
    logic [bpo_pkg::OvlW-1:0]      s4_ovl_reg;
    logic                          s4_area_nz_reg;
    logic [bpo_pkg::RhsW-1:0]      s4_rhs_reg;
    logic                          s4_wr_ok_reg;
    logic                          s4_hr_ok_reg;
    logic [bpo_pkg::RhsW-1:0]      s4_rhs_next;

    // stage 5: final compare into output register
    logic                          s5_valid_reg;
    bpo_pkg::match_result_t        s5_result_reg;
    bpo_pkg::match_result_t        s5_result_next;
    logic [bpo_pkg::LhsW-1:0]      lhs;
    logic                          ov_ok;

    always_comb
    begin
        s3_area_sum_next = bpo_pkg::AreaSumW'(prod.area1) + bpo_pkg::AreaSumW'(prod.area2);
        w1_scaled = {8'd0, prod.w1, 8'd0};
        h1_scaled = {8'd0, prod.h1, 8'd0};
        s3_wr_ok_next = !prod.w2_zero && (w1_scaled >= prod.w_lo) && (w1_scaled <= prod.w_hi);
        s3_hr_ok_next = !prod.h2_zero && (h1_scaled >= prod.h_lo) && (h1_scaled <= prod.h_hi);
    end

    always_comb
    begin
        s4_rhs_next = bpo_pkg::RhsW'(min_overlap) * bpo_pkg::RhsW'(s3_area_sum_reg);
    end

    always_comb
    begin
        lhs   = {s4_ovl_reg, {(bpo_pkg::CoordW + 1){1'b0}}};
        ov_ok = !s4_disjoint_reg && s4_area_nz_reg && (lhs > bpo_pkg::LhsW'(s4_rhs_reg));
        s5_result_next.disjoint        = s4_disjoint_reg;
        s5_result_next.overlap_ok      = ov_ok;
        s5_result_next.width_ratio_ok  = s4_wr_ok_reg;
        s5_result_next.height_ratio_ok = s4_hr_ok_reg;
        s5_result_next.accepted        = ov_ok && s4_wr_ok_reg && s4_hr_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_disjoint_reg <= prod.disjoint;
        s3_ovl_reg      <= prod.ovl_prod;
        s3_area_sum_reg <= s3_area_sum_next;
        s3_wr_ok_reg    <= s3_wr_ok_next;
        s3_hr_ok_reg    <= s3_hr_ok_next;

        s4_disjoint_reg <= s3_disjoint_reg;
        s4_ovl_reg      <= s3_ovl_reg;
        s4_area_nz_reg  <= (s3_area_sum_reg != '0);
        s4_rhs_reg      <= s4_rhs_next;
        s4_wr_ok_reg    <= s3_wr_ok_reg;
        s4_hr_ok_reg    <= s3_hr_ok_reg;

        s5_result_reg   <= s5_result_next;
    end

    assign out_valid = s5_valid_reg;
    assign result    = s5_result_reg;

endmodule
`default_nettype wire

[rtl/core/box_pair_overlap_check_unit.sv]
// Channel   Ports                           Beat taken when
// -------   -----------------------------   ---------------------------
// input     start, busy, boxes              rising edge, start & !busy
// result    done, result                    rising edge with done high
// config    cfg_write, cfg_index, cfg_data  rising edge with cfg_write high
//
// Five-stage pipeline: edges/extents, multipliers, area sum and ratio
// compares, threshold product, overlap compare. One pair per cycle; busy
// stays low and the pipeline never holds. Results leave from stage five.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module box_pair_overlap_check_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire bpo_pkg::box_pair_t              boxes,
    output logic                                 done,
    output bpo_pkg::match_result_t               result,
    input  wire logic                            cfg_write,
    input  wire logic [bpo_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [bpo_pkg::CoordW-1:0]      cfg_data
);

    bpo_pkg::cfg_t   cfg_reg;
    bpo_pkg::cfg_t   cfg_next;
    logic            geom_valid;
    bpo_pkg::geom_t  geom;
    logic            prod_valid;
    bpo_pkg::prod_t  prod;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (bpo_pkg::cfg_reg_e'(cfg_index))
                bpo_pkg::REG_MIN_OVERLAP:      cfg_next.min_overlap      = cfg_data;
                bpo_pkg::REG_MIN_WIDTH_RATIO:  cfg_next.min_width_ratio  = cfg_data;
                bpo_pkg::REG_MAX_WIDTH_RATIO:  cfg_next.max_width_ratio  = cfg_data;
                bpo_pkg::REG_MIN_HEIGHT_RATIO: cfg_next.min_height_ratio = cfg_data;
                bpo_pkg::REG_MAX_HEIGHT_RATIO: cfg_next.max_height_ratio = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_overlap      <= 16'd32768;
            cfg_reg.min_width_ratio  <= 16'd128;
            cfg_reg.max_width_ratio  <= 16'd512;
            cfg_reg.min_height_ratio <= 16'd128;
            cfg_reg.max_height_ratio <= 16'd512;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign busy = 1'b0;

    bpo_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .boxes     (boxes),
        .out_valid (geom_valid),
        .geom      (geom)
    );

    bpo_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .geom      (geom),
        .cfg       (cfg_reg),
        .out_valid (prod_valid),
        .prod      (prod)
    );

    bpo_decide u_decide
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (prod_valid),
        .prod        (prod),
        .min_overlap (cfg_reg.min_overlap),
        .out_valid   (done),
        .result      (result)
    );

endmodule
`default_nettype wire

[dv/tb_box_pair_overlap_check_unit.sv]
module tb_box_pair_overlap_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bpo_pkg::*;

    localparam int unsigned PipeDepth        = 5;
    localparam int unsigned CycleLimit       = 200000;
    localparam int unsigned PrintCap         = 40;
    localparam int unsigned FirstUnmappedReg = int'(REG_MAX_HEIGHT_RATIO) + 1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    box_pair_t           boxes     = '0;
    logic                done;
    match_result_t       result;
    logic                cfg_write = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CoordW-1:0]   cfg_data  = '0;

    box_pair_t           pair_q[$];
    match_result_t       verdict_q[$];
    cfg_t                thresholds = '{min_overlap: 16'd32768, min_width_ratio: 16'd128,
                                        max_width_ratio: 16'd512, min_height_ratio: 16'd128,
                                        max_height_ratio: 16'd512};
    int unsigned         idle_pct    = 0;
    bit                  hold_sender = 1'b0;

    int unsigned cycle        = 0;
    int unsigned beats_in     = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned n_accepted   = 0;
    int unsigned n_disjoint   = 0;
    int unsigned n_overlap    = 0;
    int unsigned cfg_writes   = 0;
    int unsigned holds        = 0;

    box_pair_overlap_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .boxes     (boxes),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic ratio_ok(logic [CoordW-1:0] num, logic [CoordW-1:0] den,
                                      logic [CoordW-1:0] lo, logic [CoordW-1:0] hi);
        logic [63:0] scaled;
        scaled = 64'(num) << 8;
        return (den != 0) && (scaled >= 64'(lo) * 64'(den)) && (scaled <= 64'(hi) * 64'(den));
    endfunction

    function automatic match_result_t judge_pair(box_pair_t p, cfg_t c);
        logic [EdgeW-1:0] x1, y1, x2, y2, r1, b1, r2, b2, ow, oh;
        logic [63:0]      area_sum, lhs, rhs;
        match_result_t    v;
        x1 = EdgeW'(p.first_x);
        y1 = EdgeW'(p.first_y);
        x2 = EdgeW'(p.second_x);
        y2 = EdgeW'(p.second_y);
        // edge sums carry into bit 16, no wrap
        r1 = x1 + EdgeW'(p.first_width);
        b1 = y1 + EdgeW'(p.first_height);
        r2 = x2 + EdgeW'(p.second_width);
        b2 = y2 + EdgeW'(p.second_height);
        v = '0;
        v.disjoint = (x1 > r2) || (y1 > b2) || (r1 < x2) || (b1 < y2);
        if (!v.disjoint)
        begin
            ow = ((r1 < r2) ? r1 : r2) - ((x1 > x2) ? x1 : x2);
            oh = ((b1 < b2) ? b1 : b2) - ((y1 > y2) ? y1 : y2);
            area_sum = 64'(p.first_width) * 64'(p.first_height)
                     + 64'(p.second_width) * 64'(p.second_height);
            // 2 * ow * oh in Q0.16 against threshold * area sum
            lhs = (64'(ow) * 64'(oh)) << 17;
            rhs = 64'(c.min_overlap) * area_sum;
            v.overlap_ok = (area_sum != 0) && (lhs > rhs);
        end
        v.width_ratio_ok  = ratio_ok(p.first_width, p.second_width,
                                     c.min_width_ratio, c.max_width_ratio);
        v.height_ratio_ok = ratio_ok(p.first_height, p.second_height,
                                     c.min_height_ratio, c.max_height_ratio);
        v.accepted = !v.disjoint && v.overlap_ok && v.width_ratio_ok && v.height_ratio_ok;
        return v;
    endfunction

    function automatic logic [CoordW-1:0] clamp16(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return CoordW'(v);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PrintCap)
            $display("[cycle %0d] mismatch: %s", cycle, what);
    endtask

    // driver: a beat is taken at an edge with start high and busy low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            boxes <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                verdict_q.push_back(judge_pair(boxes, thresholds));
                beats_in++;
            end
            if (!start || !busy)
            begin
                if (!hold_sender && pair_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    boxes <= pair_q.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: done is a one-cycle strobe, sampled at the edge that ends it
    always @(posedge clk)
    begin : monitor
        match_result_t want;
        string         diffs;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %b with nothing expected", result));
                end
                else
                begin
                    want  = verdict_q.pop_front();
                    diffs = "";
                    if (result.accepted !== want.accepted)
                        diffs = {diffs, " accepted"};
                    if (result.disjoint !== want.disjoint)
                        diffs = {diffs, " disjoint"};
                    if (result.overlap_ok !== want.overlap_ok)
                        diffs = {diffs, " overlap_ok"};
                    if (result.width_ratio_ok !== want.width_ratio_ok)
                        diffs = {diffs, " width_ratio_ok"};
                    if (result.height_ratio_ok !== want.height_ratio_ok)
                        diffs = {diffs, " height_ratio_ok"};
                    if (diffs != "")
                        report_mismatch($sformatf("result %0d wrong in%s: got %b want %b",
                                                  results_seen, diffs, result, want));
                    n_accepted += want.accepted;
                    n_disjoint += want.disjoint;
                    n_overlap  += want.overlap_ok;
                end
                results_seen++;
            end
            else if (done !== 1'b0)
            begin
                report_mismatch("done is unknown");
            end
        end
    end

    always @(posedge clk)
    begin
        cycle++;
        if (cycle > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle, verdict_q.size());
            $display("tb_box_pair_overlap_check_unit failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_MIN_OVERLAP:      thresholds.min_overlap      = val;
            REG_MIN_WIDTH_RATIO:  thresholds.min_width_ratio  = val;
            REG_MAX_WIDTH_RATIO:  thresholds.max_width_ratio  = val;
            REG_MIN_HEIGHT_RATIO: thresholds.min_height_ratio = val;
            REG_MAX_HEIGHT_RATIO: thresholds.max_height_ratio = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic set_thresholds(cfg_t c);
        write_reg(REG_MIN_OVERLAP,      c.min_overlap);
        write_reg(REG_MIN_WIDTH_RATIO,  c.min_width_ratio);
        write_reg(REG_MAX_WIDTH_RATIO,  c.max_width_ratio);
        write_reg(REG_MIN_HEIGHT_RATIO, c.min_height_ratio);
        write_reg(REG_MAX_HEIGHT_RATIO, c.max_height_ratio);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pair_q.size() != 0 || start || verdict_q.size() != 0);
        repeat (PipeDepth + 2) @(negedge clk);
    endtask

    task automatic add_pair(int x1, int y1, int w1, int h1, int x2, int y2, int w2, int h2);
        box_pair_t p;
        p.first_x       = clamp16(x1);
        p.first_y       = clamp16(y1);
        p.first_width   = clamp16(w1);
        p.first_height  = clamp16(h1);
        p.second_x      = clamp16(x2);
        p.second_y      = clamp16(y2);
        p.second_width  = clamp16(w2);
        p.second_height = clamp16(h2);
        pair_q.push_back(p);
    endtask

    task automatic queue_corner_pairs();
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);                    // zero area sum, empty box two
        add_pair(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
        add_pair(1000, 1000, 400, 300, 1000, 1000, 400, 300);
        add_pair(0, 0, 100, 100, 50, 0, 100, 100);           // overlap exactly one half
        add_pair(0, 0, 100, 100, 49, 0, 100, 100);
        add_pair(500, 0, 100, 100, 0, 0, 499, 100);          // apart, box one to the right
        add_pair(500, 0, 100, 100, 0, 0, 500, 100);          // touching edge
        add_pair(0, 0, 100, 100, 101, 0, 100, 100);          // apart, box one to the left
        add_pair(0, 0, 100, 100, 100, 0, 100, 100);
        add_pair(0, 500, 100, 100, 0, 0, 100, 499);          // apart vertically
        add_pair(0, 0, 100, 100, 0, 101, 100, 100);
        add_pair(0, 0, 100, 100, 0, 100, 100, 100);
        add_pair(0, 0, 100, 100, 10, 10, 0, 50);             // box two without width
        add_pair(0, 0, 100, 100, 10, 10, 50, 0);             // box two without height
        add_pair(0, 0, 128, 256, 0, 0, 256, 256);            // width ratio on the bounds
        add_pair(0, 0, 127, 256, 0, 0, 256, 256);
        add_pair(0, 0, 512, 256, 0, 0, 256, 256);
        add_pair(0, 0, 513, 256, 0, 0, 256, 256);
        add_pair(0, 0, 256, 128, 0, 0, 256, 256);            // height ratio on the bounds
        add_pair(0, 0, 256, 513, 0, 0, 256, 256);
        add_pair(65535, 65535, 65535, 65535, 0, 0, 65535, 65535); // 17-bit edges touch
        add_pair(65535, 0, 1, 1, 65520, 0, 32, 1);
        add_pair(50, 50, 0, 0, 0, 0, 100, 100);              // point inside box two
    endtask

    task automatic run_phase(int unsigned n, int unsigned pct, bit hold_once);
        box_pair_t   p;
        int unsigned kind;
        int          x1, y1, w1, h1, x2, y2, w2, h2;
        idle_pct = pct;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(99);
            p = {$urandom, $urandom, $urandom, $urandom};
            if (kind < 72)
            begin
                // a plausible candidate pair near the decision boundaries
                w2 = $urandom_range(1, 3000);
                h2 = $urandom_range(1, 3000);
                if ($urandom_range(3) == 0)
                begin
                    w2 = 256 * $urandom_range(1, 12);
                    w1 = (($urandom_range(1) != 0) ? int'(thresholds.min_width_ratio)
                                                   : int'(thresholds.max_width_ratio)) * (w2 / 256);
                    h2 = 256 * $urandom_range(1, 12);
                    h1 = (($urandom_range(1) != 0) ? int'(thresholds.min_height_ratio)
                                                   : int'(thresholds.max_height_ratio)) * (h2 / 256);
                end
                else
                begin
                    w1 = w2 * $urandom_range(64, 640) / 256;
                    h1 = h2 * $urandom_range(64, 640) / 256;
                end
                w1 = int'(clamp16(w1));
                h1 = int'(clamp16(h1));
                x2 = $urandom_range(0, 62000);
                y2 = $urandom_range(0, 62000);
                x1 = x2 + int'($urandom_range(0, w1 + w2)) - w1;
                y1 = y2 + int'($urandom_range(0, h1 + h2)) - h1;
                if (kind >= 60)
                begin
                    case ($urandom_range(3))
                        0: x1 = x2 + w2;
                        1: x1 = x2 - w1;
                        2: y1 = y2 + h2;
                        default: y1 = y2 - h1;
                    endcase
                end
                p.first_x       = clamp16(x1);
                p.first_y       = clamp16(y1);
                p.first_width   = CoordW'(w1);
                p.first_height  = CoordW'(h1);
                p.second_x      = CoordW'(x2);
                p.second_y      = CoordW'(y2);
                p.second_width  = CoordW'(w2);
                p.second_height = CoordW'(h2);
            end
            else if (kind < 86)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    case ($urandom_range(5))
                        0: p[k*CoordW +: CoordW] = 16'h0000;
                        1: p[k*CoordW +: CoordW] = 16'h0001;
                        2: p[k*CoordW +: CoordW] = 16'hFFFF;
                        3: p[k*CoordW +: CoordW] = 16'hFFFE;
                        4: p[k*CoordW +: CoordW] = 16'h8000;
                        default: ;
                    endcase
                end
            end
            pair_q.push_back(p);
        end
        if (hold_once)
        begin
            // stop feeding midway and let the pipeline run dry
            while (pair_q.size() > n / 2)
                @(negedge clk);
            hold_sender = 1'b1;
            while (start || verdict_q.size() != 0)
                @(negedge clk);
            hold_sender = 1'b0;
            holds++;
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        cfg_t c;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults, back to back
        queue_corner_pairs();
        run_phase(200, 0, 1'b0);

        // widest bounds, zero threshold; unmapped indexes must be dropped
        c = '{min_overlap: 16'd0, min_width_ratio: 16'd0, max_width_ratio: 16'hFFFF,
              min_height_ratio: 16'd0, max_height_ratio: 16'hFFFF};
        set_thresholds(c);
        for (int i = FirstUnmappedReg; i < (1 << CfgIdxW); i++)
            write_reg(CfgIdxW'(i), 16'($urandom));
        run_phase(200, 45, 1'b1);

        // everything at full scale
        c = '{min_overlap: 16'hFFFF, min_width_ratio: 16'hFFFF, max_width_ratio: 16'hFFFF,
              min_height_ratio: 16'hFFFF, max_height_ratio: 16'hFFFF};
        set_thresholds(c);
        queue_corner_pairs();
        run_phase(150, 0, 1'b0);

        c.min_overlap      = 16'($urandom);
        c.min_width_ratio  = 16'($urandom);
        c.max_width_ratio  = 16'($urandom);
        c.min_height_ratio = 16'($urandom);
        c.max_height_ratio = 16'($urandom);
        set_thresholds(c);
        run_phase(150, 34, 1'b0);

        c.min_overlap      = 16'($urandom_range(16384, 52000));
        c.min_width_ratio  = 16'($urandom_range(64, 256));
        c.max_width_ratio  = 16'($urandom_range(256, 1024));
        c.min_height_ratio = 16'($urandom_range(64, 256));
        c.max_height_ratio = 16'($urandom_range(256, 1024));
        set_thresholds(c);
        run_phase(150, 45, 1'b1);

        $display("%0d box pairs over 5 threshold settings, %0d register writes, %0d sender holds",
                 beats_in, cfg_writes, holds);
        $display("%0d results: %0d accepted, %0d disjoint, %0d over threshold, %0d mismatches",
                 results_seen, n_accepted, n_disjoint, n_overlap, mismatches);
        if (mismatches == 0)
            $display("tb_box_pair_overlap_check_unit passed");
        else
            $display("tb_box_pair_overlap_check_unit failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/bpo_pkg.sv
rtl/core/bpo_geom.sv
rtl/core/bpo_mult.sv
rtl/core/bpo_decide.sv
rtl/core/box_pair_overlap_check_unit.sv
dv/tb_box_pair_overlap_check_unit.sv
